// ===== rtl/tfe_pkg.sv =====
// Shared types and constants of the telemetry frame encoder.
package tfe_pkg;

    localparam int unsigned HALF_W     = 16;
    localparam int unsigned MAX_HALVES = 8;
    localparam int unsigned IN_DATA_W  = HALF_W * MAX_HALVES;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned FIFO_DEPTH = 2;

    localparam logic [BYTE_W-1:0] HDR_BYTE     = 8'hAB;
    localparam logic [BYTE_W-1:0] LEN_HI_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] RST_SOURCE   = 8'h00;
    localparam logic [BYTE_W-1:0] RST_DEST     = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_FUNCTION = 8'hF1;

    // Byte positions at the head of a frame.
    localparam int unsigned POS_HDR     = 0;
    localparam int unsigned POS_SOURCE  = 1;
    localparam int unsigned POS_DEST    = 2;
    localparam int unsigned POS_FUNC    = 3;
    localparam int unsigned POS_LEN_LO  = 4;
    localparam int unsigned POS_LEN_HI  = 5;
    localparam int unsigned POS_PAYLOAD = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE   = 2'd0,
        CFG_DEST     = 2'd1,
        CFG_FUNCTION = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] source_address;
        logic [BYTE_W-1:0] dest_address;
        logic [BYTE_W-1:0] function_id;
    } t_cfg;

endpackage

// ===== rtl/telemetry_frame_encoder.sv =====
// Telemetry frame encoder: top level joining front end, queue and byte sequencer.
//
// Input stream: one transfer carries a sample set of eight 16-bit halves; the
// first PAYLOAD_HALVES of them go into the frame, each low byte first.
// Output stream: one transfer per frame byte; a frame is 0xAB, source,
// destination and function bytes, a two-byte length, the payload, a sum check
// and an add check; tlast marks the add check. 8 + 2*PAYLOAD_HALVES transfers
// per frame, 24 with the default.
// When the block is idle, the header of a set passes through the queue, the
// sequencer's load and the output register. Throughput: one byte per cycle while
// the receiver is ready, set by the byte sequencer and its single output port.
// A two-entry queue in front of the sequencer takes sets while a frame is still
// being sent.
// Configuration writes (source, destination, function) take effect at once;
// the user must make them while no frame is in flight; it is not enforced.
// Reset empties the queue and the output register and restores the source 0x00,
// destination 0xFF and function 0xF1. When the receiver stalls, the output byte
// holds and the sequencer waits; input is refused only when the queue is full.
module telemetry_frame_encoder #(
    parameter int unsigned PAYLOAD_HALVES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tfe_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // half0 [15:0], half1 [31:16], ... half7 [127:112]
    input  logic [tfe_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // frame_byte [7:0]
    output logic [tfe_pkg::BYTE_W-1:0]    o_m_axis_tdata,
    // last_byte
    output logic                          o_m_axis_tlast
);

    localparam int unsigned PW = tfe_pkg::HALF_W * PAYLOAD_HALVES;

    tfe_pkg::t_cfg w_cfg;
    logic          w_push;
    logic [PW-1:0] w_push_data;
    logic          w_pop;
    logic [PW-1:0] w_pop_data;
    logic          w_full;
    logic          w_empty;

    tfe_front #(
        .PAYLOAD_W (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tdata   (i_s_axis_tdata),
        .o_s_tready  (o_s_axis_tready),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_cfg       (w_cfg)
    );

    tfe_fifo #(
        .WIDTH (PW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_push_data),
        .i_pop   (w_pop),
        .o_rdata (w_pop_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tfe_back #(
        .PAYLOAD_HALVES (PAYLOAD_HALVES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_fifo_empty (w_empty),
        .i_fifo_rdata (w_pop_data),
        .o_pop        (w_pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (o_m_axis_tdata),
        .o_m_tlast    (o_m_axis_tlast)
    );

endmodule

// ===== rtl/tfe_fifo.sv =====
// Small register queue that carries payload sets from the front end to the back end.
module tfe_fifo #(
    parameter int unsigned WIDTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned DEPTH = tfe_pkg::FIFO_DEPTH;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== rtl/tfe_front.sv =====
// Front end: configuration registers and acceptance of sample sets into the queue.
module tfe_front #(
    parameter int unsigned PAYLOAD_W = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tfe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tfe_pkg::BYTE_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic [tfe_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                           o_s_tready,
    input  logic                           i_fifo_full,
    output logic                           o_push,
    output logic [PAYLOAD_W-1:0]           o_push_data,
    output tfe_pkg::t_cfg                  o_cfg
);

    tfe_pkg::t_cfg r_cfg;

    assign o_s_tready  = !i_fifo_full;
    assign o_push      = i_s_tvalid && !i_fifo_full;
    // Only the halves that go into the frame are kept.
    assign o_push_data = i_s_tdata[PAYLOAD_W-1:0];
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_address <= tfe_pkg::RST_SOURCE;
            r_cfg.dest_address   <= tfe_pkg::RST_DEST;
            r_cfg.function_id    <= tfe_pkg::RST_FUNCTION;
        end else if (i_cfg_we) begin
            unique case (tfe_pkg::t_cfg_idx'(i_cfg_idx))
                tfe_pkg::CFG_SOURCE:   r_cfg.source_address <= i_cfg_wdata;
                tfe_pkg::CFG_DEST:     r_cfg.dest_address   <= i_cfg_wdata;
                tfe_pkg::CFG_FUNCTION: r_cfg.function_id    <= i_cfg_wdata;
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

endmodule

// ===== rtl/tfe_back.sv =====
// Back end: byte sequencer that builds the frame, the two check bytes and the output register.
module tfe_back #(
    parameter int unsigned PAYLOAD_HALVES = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  tfe_pkg::t_cfg                             i_cfg,
    input  logic                                      i_fifo_empty,
    input  logic [tfe_pkg::HALF_W*PAYLOAD_HALVES-1:0] i_fifo_rdata,
    output logic                                      o_pop,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [tfe_pkg::BYTE_W-1:0]                o_m_tdata,
    output logic                                      o_m_tlast
);

    localparam int unsigned PW        = tfe_pkg::HALF_W * PAYLOAD_HALVES;
    localparam int unsigned FRAME_LEN = tfe_pkg::POS_PAYLOAD + 2 * PAYLOAD_HALVES + 2;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
    localparam int unsigned POS_SUM   = FRAME_LEN - 2;
    localparam int unsigned POS_ADD   = FRAME_LEN - 1;
    localparam logic [tfe_pkg::BYTE_W-1:0] LEN_LO =
        tfe_pkg::BYTE_W'(2 * PAYLOAD_HALVES);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [PW-1:0]               r_payload;
    logic [tfe_pkg::BYTE_W-1:0]  r_sum;
    logic [tfe_pkg::BYTE_W-1:0]  r_add;
    logic                        r_out_valid;
    logic [tfe_pkg::BYTE_W-1:0]  r_out_data;
    logic                        r_out_last;

    logic                        w_free;
    logic                        w_emit;
    logic                        w_end;
    logic                        w_load;
    logic                        w_in_payload;
    logic                        w_summed;
    logic [tfe_pkg::BYTE_W-1:0]  w_byte;
    logic [tfe_pkg::BYTE_W-1:0]  n_sum;
    logic [tfe_pkg::BYTE_W-1:0]  n_add;

    // The output register may be refilled when it is empty or being taken this cycle.
    assign w_free = !r_out_valid || i_m_tready;
    assign w_emit = r_busy && w_free;
    assign w_end  = w_emit && (r_cnt == CNT_W'(POS_ADD));
    // The next set is loaded on the cycle the add check leaves, so frames run back to back.
    assign w_load = (!r_busy || w_end) && !i_fifo_empty;
    assign o_pop  = w_load;

    assign w_in_payload = (r_cnt >= CNT_W'(tfe_pkg::POS_PAYLOAD)) &&
                          (r_cnt < CNT_W'(POS_SUM));
    assign w_summed     = (r_cnt < CNT_W'(POS_SUM));

    always_comb begin
        case (r_cnt)
            CNT_W'(tfe_pkg::POS_HDR):    w_byte = tfe_pkg::HDR_BYTE;
            CNT_W'(tfe_pkg::POS_SOURCE): w_byte = i_cfg.source_address;
            CNT_W'(tfe_pkg::POS_DEST):   w_byte = i_cfg.dest_address;
            CNT_W'(tfe_pkg::POS_FUNC):   w_byte = i_cfg.function_id;
            CNT_W'(tfe_pkg::POS_LEN_LO): w_byte = LEN_LO;
            CNT_W'(tfe_pkg::POS_LEN_HI): w_byte = tfe_pkg::LEN_HI_BYTE;
            CNT_W'(POS_SUM):             w_byte = r_sum;
            CNT_W'(POS_ADD):             w_byte = r_add;
            default:                     w_byte = r_payload[tfe_pkg::BYTE_W-1:0];
        endcase
        n_sum = r_sum + w_byte;
        n_add = r_add + n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= w_byte;
            r_out_last <= (r_cnt == CNT_W'(POS_ADD));
            if (w_in_payload) begin
                r_payload <= {8'h00, r_payload[PW-1:tfe_pkg::BYTE_W]};
            end
            if (w_summed) begin
                r_sum <= n_sum;
                r_add <= n_add;
            end
        end
        if (w_load) begin
            r_payload <= i_fifo_rdata;
            r_sum     <= '0;
            r_add     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_cnt <= '0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_cnt == CNT_W'(tfe_pkg::POS_HDR))
        |=> (o_m_tvalid && o_m_tdata == tfe_pkg::HDR_BYTE && !o_m_tlast))
        else $error("frame did not open with the header byte");

    a_last_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end |=> (o_m_tvalid && o_m_tlast))
        else $error("add check byte not marked as last");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt <= CNT_W'(POS_ADD)))
        else $error("byte counter ran past the frame");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the telemetry frame encoder: frames predicted per sample set.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_HALVES    = 8;
    localparam int unsigned FRAME_BYTES = 8 + 2 * N_HALVES;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_SETS   = 350;
    // The index port is two bits wide; this code names no register.
    localparam logic [tfe_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    typedef struct {
        logic [tfe_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_frame_byte;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [tfe_pkg::CFG_IDX_W-1:0] cfg_idx     = '0;
    logic [tfe_pkg::BYTE_W-1:0]    cfg_wdata   = '0;
    logic                          s_valid     = 1'b0;
    logic [tfe_pkg::IN_DATA_W-1:0] s_data      = '0;
    logic                          m_ready     = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic [tfe_pkg::BYTE_W-1:0]    m_data;
    logic                          m_last;

    // Local copy of the register file, updated as writes are issued.
    tfe_pkg::t_cfg cfg_model;
    t_frame_byte   frame_bytes_due[$];

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;
    int unsigned err_count    = 0;
    int unsigned sets_sent    = 0;
    int unsigned bytes_seen   = 0;
    int unsigned cfg_writes   = 0;

    telemetry_frame_encoder #(
        .PAYLOAD_HALVES (N_HALVES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d frame bytes outstanding", $realtime,
                     frame_bytes_due.size());
            $display("telemetry_frame_encoder verification failed");
            $finish;
        end
    end

    // Receiver: a requested hold-off is counted down here, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = !(sink_idle_en && ($urandom_range(99) < 22));
        end
    end

    // Works out the whole frame for one sample set and queues its bytes.
    function automatic void predict_frame(input logic [tfe_pkg::IN_DATA_W-1:0] halves);
        logic [tfe_pkg::BYTE_W-1:0] bytes[$];
        logic [tfe_pkg::BYTE_W-1:0] sum_chk;
        logic [tfe_pkg::BYTE_W-1:0] add_chk;
        logic [tfe_pkg::HALF_W-1:0] h;
        t_frame_byte                fb;
        bytes.push_back(tfe_pkg::HDR_BYTE);
        bytes.push_back(cfg_model.source_address);
        bytes.push_back(cfg_model.dest_address);
        bytes.push_back(cfg_model.function_id);
        bytes.push_back(tfe_pkg::BYTE_W'(2 * N_HALVES));
        bytes.push_back(tfe_pkg::BYTE_W'((2 * N_HALVES) >> 8));
        for (int i = 0; i < N_HALVES; i++) begin
            h = halves[i*tfe_pkg::HALF_W +: tfe_pkg::HALF_W];
            bytes.push_back(h[7:0]);
            bytes.push_back(h[15:8]);
        end
        sum_chk = '0;
        add_chk = '0;
        foreach (bytes[i]) begin
            sum_chk = sum_chk + bytes[i];
            add_chk = add_chk + sum_chk;
        end
        bytes.push_back(sum_chk);
        bytes.push_back(add_chk);
        foreach (bytes[i]) begin
            fb.data = bytes[i];
            fb.last = (i == FRAME_BYTES - 1);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    // Output check: every byte transfer against the oldest predicted byte.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && m_valid && m_ready) begin
            if (frame_bytes_due.size() == 0) begin
                err_count++;
                $display("%0t: unexpected byte, expected none, actual data %02h last %0b",
                         $realtime, m_data, m_last);
            end else begin
                want = frame_bytes_due.pop_front();
                bytes_seen++;
                if (m_data !== want.data) begin
                    err_count++;
                    $display("%0t: frame byte mismatch, expected %02h, actual %02h",
                             $realtime, want.data, m_data);
                end
                if (m_last !== want.last) begin
                    err_count++;
                    $display("%0t: tlast mismatch, expected %0b, actual %0b",
                             $realtime, want.last, m_last);
                end
            end
        end
    end

    // Offers one sample set; entered and left at a falling edge.
    task automatic send_set(input logic [tfe_pkg::IN_DATA_W-1:0] halves);
        while (src_idle_en && ($urandom_range(99) < 22)) begin
            s_valid = 1'b0;
            @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = halves;
        do @(posedge i_clk); while (!s_ready);
        predict_frame(halves);
        sets_sent++;
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        s_valid = 1'b0;
    endtask

    task automatic wait_idle();
        stop_sending();
        while (frame_bytes_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [tfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tfe_pkg::BYTE_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
        cfg_writes++;
        case (idx)
            tfe_pkg::CFG_SOURCE:   cfg_model.source_address = val;
            tfe_pkg::CFG_DEST:     cfg_model.dest_address   = val;
            tfe_pkg::CFG_FUNCTION: cfg_model.function_id    = val;
            default:               ;
        endcase
    endtask

    function automatic logic [tfe_pkg::IN_DATA_W-1:0] random_set();
        logic [tfe_pkg::IN_DATA_W-1:0] v;
        int unsigned                   pick;
        for (int i = 0; i < N_HALVES; i++) begin
            pick = $urandom_range(99);
            if (pick < 10)
                v[i*tfe_pkg::HALF_W +: tfe_pkg::HALF_W] = '0;
            else if (pick < 20)
                v[i*tfe_pkg::HALF_W +: tfe_pkg::HALF_W] = '1;
            else
                v[i*tfe_pkg::HALF_W +: tfe_pkg::HALF_W] = tfe_pkg::HALF_W'($urandom);
        end
        return v;
    endfunction

    task automatic test_reset_defaults();
        send_set('0);
        send_set('1);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        logic [tfe_pkg::IN_DATA_W-1:0] v;
        send_set({tfe_pkg::MAX_HALVES{16'h5555}});
        send_set({tfe_pkg::MAX_HALVES{16'hAAAA}});
        for (int i = 0; i < N_HALVES; i++) begin
            v = '0;
            v[i*tfe_pkg::HALF_W +: tfe_pkg::HALF_W] = '1;
            send_set(v);
        end
        send_set({16'h0001, 16'h8000, 16'h00FF, 16'hFF00,
                  16'h7FFF, 16'hFFFE, 16'h0100, 16'h0080});
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(tfe_pkg::CFG_SOURCE, 8'hFF);
        write_reg(tfe_pkg::CFG_DEST, 8'h00);
        write_reg(tfe_pkg::CFG_FUNCTION, 8'h00);
        send_set('1);
        send_set('0);
        wait_idle();
        write_reg(tfe_pkg::CFG_SOURCE, 8'h00);
        write_reg(tfe_pkg::CFG_DEST, 8'hFF);
        write_reg(tfe_pkg::CFG_FUNCTION, 8'hFF);
        send_set('1);
        wait_idle();
        // A write to the unused index must leave every register alone.
        write_reg(CFG_NO_REG, 8'h5A);
        send_set(random_set());
        wait_idle();
    endtask

    task automatic test_random_sets();
        for (int n = 0; n < RAND_SETS; n++) begin
            if (n % 50 == 0) begin
                wait_idle();
                if (n == 200) begin
                    write_reg(tfe_pkg::CFG_SOURCE, 8'hFF);
                    write_reg(tfe_pkg::CFG_DEST, 8'hFF);
                    write_reg(tfe_pkg::CFG_FUNCTION, 8'hFF);
                end else begin
                    write_reg(tfe_pkg::CFG_SOURCE, tfe_pkg::BYTE_W'($urandom));
                    write_reg(tfe_pkg::CFG_DEST, tfe_pkg::BYTE_W'($urandom));
                    write_reg(tfe_pkg::CFG_FUNCTION, tfe_pkg::BYTE_W'($urandom));
                    if ($urandom_range(1))
                        write_reg(CFG_NO_REG, tfe_pkg::BYTE_W'($urandom));
                end
            end
            // One long stretch runs with neither side idling.
            src_idle_en  = !(n >= 120 && n < 190);
            sink_idle_en = src_idle_en;
            send_set(random_set());
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_backpressure();
        // The receiver holds off while the sender keeps offering, so the queue fills.
        src_idle_en = 1'b0;
        hold_left   = HOLD_CYCLES;
        repeat (6) send_set(random_set());
        src_idle_en = 1'b1;
        // The sender then pauses until every byte is out.
        wait_idle();
        repeat (3) send_set(random_set());
        wait_idle();
    endtask

    initial begin
        int unsigned waited;
        cfg_model.source_address = tfe_pkg::RST_SOURCE;
        cfg_model.dest_address   = tfe_pkg::RST_DEST;
        cfg_model.function_id    = tfe_pkg::RST_FUNCTION;
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_field_extremes();
        test_config_extremes();
        test_backpressure();
        test_random_sets();

        stop_sending();
        waited = 0;
        while (frame_bytes_due.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (frame_bytes_due.size() != 0) begin
            err_count++;
            $display("%0t: %0d frame bytes never arrived", $realtime, frame_bytes_due.size());
        end

        $display("Covered %0d sample sets and %0d frame bytes over %0d register writes,",
                 sets_sent, bytes_seen, cfg_writes);
        $display("with register extremes, random stalls on both sides and a long output hold-off.");
        if (err_count == 0) begin
            $display("telemetry_frame_encoder verification clean");
        end else begin
            $display("telemetry_frame_encoder verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tfe_pkg.sv
rtl/tfe_fifo.sv
rtl/tfe_front.sv
rtl/tfe_back.sv
rtl/telemetry_frame_encoder.sv
tb/sv/tb.sv
